// ----- hw/rtl/ufpd_pkg.sv -----
// shared types, character codes and helpers for the form pair decoder
// no dependencies; imported by the front, queue, back and top-level modules
package ufpd_pkg;

    // sizes
    localparam int KEEP_W      = 10;
    localparam int LIMIT_W     = 8;
    localparam int CFG_DATA_W  = 10;
    localparam int FIELD_BYTES = 1024;
    localparam int MAX_PAIRS   = 32;
    localparam int RES_MAX     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [KEEP_W-1:0]  KEEP_MAX =
        (FIELD_BYTES - 1 > (1 << KEEP_W) - 1) ? '1 : KEEP_W'(FIELD_BYTES - 1);
    localparam logic [LIMIT_W-1:0] PAIR_CAP = LIMIT_W'(MAX_PAIRS);
    localparam logic [LIMIT_W-1:0] PAIRS_SAT = '1;

    // register reset values
    localparam logic [KEEP_W-1:0]  KEY_KEEP_RST   = 10'd63;
    localparam logic [KEEP_W-1:0]  VALUE_KEEP_RST = 10'd255;

    // characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [3:0] HEX_ALPHA_OFS = 4'(10 - 1);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_KEY_KEEP   = 2'd0,
        CFG_VALUE_KEEP = 2'd1,
        CFG_PAIR_LIMIT = 2'd2
    } t_cfg_idx;

    // all results caused by one request
    typedef struct packed {
        logic [1:0]        last_idx;
        logic              has_bytes;
        logic              in_value;
        logic              pair_end;
        logic              string_end;
        logic [2:0][7:0]   bytes;
    } t_bundle;

    function automatic logic hex_ok(logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [3:0] v;
        if (c <= 8'h39) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + HEX_ALPHA_OFS;
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/ufpd_front.sv -----
// front part: configuration registers, pair/segment state and per-byte decode
// depends on ufpd_pkg; produces at most one result bundle per request into the queue
module ufpd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [ufpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_push,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_in_final,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output ufpd_pkg::t_bundle             o_q_data
);
    import ufpd_pkg::*;

    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
    } t_emit;

    function automatic t_emit add_byte(t_emit e, logic [7:0] x);
        t_emit r;
        r = e;
        if (e.cnt != 2'(RES_MAX)) begin
            r.bytes[e.cnt] = x;
            r.cnt          = e.cnt + 2'd1;
        end
        return r;
    endfunction

    logic [KEEP_W-1:0]  r_key_keep, r_value_keep;
    logic [LIMIT_W-1:0] r_pair_limit;

    logic               r_seg_is_value, n_seg_is_value;
    logic [KEEP_W-1:0]  r_seg_position, n_seg_position;
    logic [1:0]         r_held_count, n_held_count;
    logic [7:0]         r_held1, n_held1;
    logic [LIMIT_W-1:0] r_pairs_made, n_pairs_made;
    logic               r_dropping, n_dropping;

    logic               accept;
    logic               drop_now;
    logic [KEEP_W-1:0]  keep_raw, keep;
    logic [LIMIT_W-1:0] limit;
    logic [7:0]         st_byte;
    logic               st_hold;
    t_emit              em;
    logic               pair_end, str_end, do_flush;

    // effective keep and limit
    assign keep_raw = r_seg_is_value ? r_value_keep : r_key_keep;
    assign keep     = (keep_raw > KEEP_MAX) ? KEEP_MAX : keep_raw;
    assign limit    = (r_pair_limit < PAIR_CAP) ? r_pair_limit : PAIR_CAP;
    assign drop_now = r_dropping || (r_pairs_made >= limit);
    assign accept   = i_push && !i_q_full;

    // what a byte that starts fresh turns into
    assign st_hold = (i_in_byte == CH_PCT);
    assign st_byte = (i_in_byte == CH_PLUS) ? CH_SPACE : i_in_byte;

    // decode one byte against the current state
    always_comb begin
        em             = '0;
        n_held_count   = r_held_count;
        n_held1        = r_held1;
        n_seg_is_value = r_seg_is_value;
        n_seg_position = r_seg_position;
        n_pairs_made   = r_pairs_made;
        n_dropping     = r_dropping;
        pair_end       = 1'b0;
        str_end        = 1'b0;
        do_flush       = 1'b0;

        if (drop_now) begin
            n_dropping = 1'b1;
            if (i_in_final) begin
                str_end = 1'b1;
            end
        end else begin
            if (i_in_byte == CH_AMP) begin
                do_flush = 1'b1;
                pair_end = 1'b1;
            end else if (i_in_byte == CH_EQ && !r_seg_is_value) begin
                do_flush       = 1'b1;
                n_seg_is_value = 1'b1;
                n_seg_position = '0;
            end else if (r_seg_position < keep) begin
                case (r_held_count)
                    2'd0: begin
                        if (st_hold) begin
                            n_held_count = 2'd1;
                        end else begin
                            em = add_byte(em, st_byte);
                        end
                    end
                    2'd1: begin
                        if (hex_ok(i_in_byte)) begin
                            n_held1      = i_in_byte;
                            n_held_count = 2'd2;
                        end else begin
                            em = add_byte(em, CH_PCT);
                            if (st_hold) begin
                                n_held_count = 2'd1;
                            end else begin
                                n_held_count = 2'd0;
                                em = add_byte(em, st_byte);
                            end
                        end
                    end
                    default: begin
                        if (hex_ok(i_in_byte) && hex_ok(r_held1)) begin
                            n_held_count = 2'd0;
                            em = add_byte(em, {hex_val(r_held1), hex_val(i_in_byte)});
                        end else begin
                            em = add_byte(em, CH_PCT);
                            em = add_byte(em, r_held1);
                            if (st_hold) begin
                                n_held_count = 2'd1;
                            end else begin
                                n_held_count = 2'd0;
                                em = add_byte(em, st_byte);
                            end
                        end
                    end
                endcase
                n_seg_position = r_seg_position + 1'b1;
                if (n_seg_position >= keep) begin
                    do_flush = 1'b1;
                end
            end else begin
                do_flush = 1'b1;
            end
            if (i_in_final) begin
                do_flush = 1'b1;
                pair_end = 1'b1;
                str_end  = 1'b1;
            end
        end

        // pending escape goes out literally
        if (do_flush) begin
            if (n_held_count != 2'd0) begin
                em = add_byte(em, CH_PCT);
            end
            if (n_held_count == 2'd2) begin
                em = add_byte(em, n_held1);
            end
            n_held_count = 2'd0;
        end

        // pair bookkeeping
        if (pair_end) begin
            if (r_pairs_made != PAIRS_SAT) begin
                n_pairs_made = r_pairs_made + 1'b1;
            end
            n_dropping     = (n_pairs_made >= limit);
            n_seg_is_value = 1'b0;
            n_seg_position = '0;
        end

        // end of string returns to the idle state
        if (str_end) begin
            n_seg_is_value = 1'b0;
            n_seg_position = '0;
            n_held_count   = 2'd0;
            n_held1        = '0;
            n_pairs_made   = '0;
            n_dropping     = 1'b0;
        end
    end

    // bundle toward the queue
    always_comb begin
        o_q_data            = '0;
        o_q_data.bytes      = em.bytes;
        o_q_data.has_bytes  = (em.cnt != 2'd0);
        o_q_data.last_idx   = (em.cnt != 2'd0) ? em.cnt - 2'd1 : 2'd0;
        o_q_data.in_value   = (em.cnt != 2'd0) && r_seg_is_value;
        o_q_data.pair_end   = pair_end;
        o_q_data.string_end = str_end;
    end
    assign o_q_push = accept && ((em.cnt != 2'd0) || pair_end || str_end);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_keep   <= KEY_KEEP_RST;
            r_value_keep <= VALUE_KEEP_RST;
            r_pair_limit <= PAIR_CAP;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_KEEP:   r_key_keep   <= i_cfg_data[KEEP_W-1:0];
                CFG_VALUE_KEEP: r_value_keep <= i_cfg_data[KEEP_W-1:0];
                CFG_PAIR_LIMIT: r_pair_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_is_value <= 1'b0;
            r_seg_position <= '0;
            r_held_count   <= 2'd0;
            r_held1        <= '0;
            r_pairs_made   <= '0;
            r_dropping     <= 1'b0;
        end else if (accept) begin
            r_seg_is_value <= n_seg_is_value;
            r_seg_position <= n_seg_position;
            r_held_count   <= n_held_count;
            r_held1        <= n_held1;
            r_pairs_made   <= n_pairs_made;
            r_dropping     <= n_dropping;
        end
    end

endmodule

// ----- hw/rtl/ufpd_queue.sv -----
// short queue of result bundles between the front and back parts
// depends on ufpd_pkg for the bundle type and depth
module ufpd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ufpd_pkg::t_bundle i_data,
    output logic              o_full,
    input  logic              i_pop,
    output ufpd_pkg::t_bundle o_data,
    output logic              o_empty
);
    import ufpd_pkg::*;

    t_bundle           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/ufpd_back.sv -----
// back part: holds one bundle and hands out its results one per pop
// depends on ufpd_pkg; reads bundles from ufpd_queue
module ufpd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  ufpd_pkg::t_bundle i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_valid,
    output logic              o_in_value,
    output logic              o_pair_done,
    output logic              o_string_done,
    output logic              o_run_last
);
    import ufpd_pkg::*;

    t_bundle    r_cur;
    logic       r_cur_valid;
    logic [1:0] r_sub;
    logic       is_last, finish;

    assign is_last = (r_sub == r_cur.last_idx);
    assign finish  = r_cur_valid && i_pop && is_last;
    assign o_q_pop = !i_q_empty && (!r_cur_valid || finish);

    // result fields
    assign o_empty       = !r_cur_valid;
    assign o_byte_valid  = r_cur.has_bytes;
    assign o_out_byte    = r_cur.has_bytes ? r_cur.bytes[r_sub] : 8'd0;
    assign o_in_value    = r_cur.in_value;
    assign o_pair_done   = is_last && r_cur.pair_end;
    assign o_string_done = is_last && r_cur.string_end;
    assign o_run_last    = is_last;

    // current bundle and result index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_sub       <= 2'd0;
        end else if (o_q_pop) begin
            r_cur_valid <= 1'b1;
            r_sub       <= 2'd0;
        end else if (finish) begin
            r_cur_valid <= 1'b0;
            r_sub       <= 2'd0;
        end else if (r_cur_valid && i_pop) begin
            r_sub <= r_sub + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_data;
        end
    end

endmodule

// ----- hw/rtl/url_form_pair_decoder.sv -----
// top level of the form/query pair decoder: front, queue and back parts
// depends on ufpd_pkg, ufpd_front, ufpd_queue and ufpd_back
//
// Takes one raw byte per cycle and splits the string into key=value pairs,
// turning '+' into a space and valid %XX escapes into one byte. Each byte
// produces zero to three results; the front part decodes a byte in the cycle
// it is accepted and writes all of its results as one entry into a
// four-entry queue, and the back part hands the results out one per cycle
// while i_pop is high, from its output register. Input is taken every cycle
// while the queue has room, so sustained input rate is one byte per cycle
// as long as bytes average no more than one result each; runs of escapes
// flushed literally drain at one result per cycle and fill the queue.
// Configuration writes take effect on the next cycle and are meant to be
// made while the block is idle.
module url_form_pair_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [ufpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_in_final,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic [7:0]                      o_out_byte,
    output logic                            o_byte_valid,
    output logic                            o_in_value,
    output logic                            o_pair_done,
    output logic                            o_string_done,
    output logic                            o_run_last
);
    import ufpd_pkg::*;

    logic    q_push, q_full, q_pop, q_empty;
    t_bundle q_wdata, q_rdata;

    assign o_full = q_full;

    // byte decode and parse state
    ufpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (i_push),
        .i_in_byte  (i_in_byte),
        .i_in_final (i_in_final),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    // bundle queue
    ufpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // result serializer
    ufpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_in_value    (o_in_value),
        .o_pair_done   (o_pair_done),
        .o_string_done (o_string_done),
        .o_run_last    (o_run_last)
    );

endmodule

// ----- hw/rtl/ufpd_port_chk.sv -----
// port-level checks on the result side of the form pair decoder
// no package dependency; attached to the top level by the bind below
module ufpd_port_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_empty,
    input logic       i_pop,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_in_value,
    input logic       o_pair_done,
    input logic       o_string_done,
    input logic       o_run_last
);

    // a result without a byte exists only to carry an end mark
    a_marker_has_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_byte_valid |-> o_pair_done || o_string_done)
        else $error("result with no byte and no end mark");

    // string end is always the last result of its request
    a_string_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_string_done |-> o_run_last)
        else $error("string end not on last result");

    // key/value tag only on real bytes
    a_tag_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_byte_valid |-> !o_in_value && o_out_byte == 8'd0)
        else $error("tag or byte set on a marker result");

    // a waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_out_byte) && $stable(o_run_last))
        else $error("waiting result changed");

endmodule

bind url_form_pair_decoder ufpd_port_chk u_port_chk (.*);
